// File: rtl/tlpt_pkg.sv
// Shared constants, codes and types of the two-level page table engine.
`timescale 1ns / 1ps

package tlpt_pkg;

	localparam int DIR_ENTRIES = 1024;
	localparam int POOL_TABLES = 128;
	localparam int IDX_W = 10;
	localparam int TBL_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
	localparam int USED_W = $clog2(POOL_TABLES + 1);
	localparam int DIR_W = TBL_W + 1;
	localparam int TADDR_W = TBL_W + IDX_W;
	localparam int TSTORE_DEPTH = POOL_TABLES * DIR_ENTRIES;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [USED_W-1:0] POOL_FULL = USED_W'(POOL_TABLES);

	localparam logic [1:0] ACT_MAP = 2'd0;
	localparam logic [1:0] ACT_UNMAP = 2'd1;
	localparam logic [1:0] ACT_XLATE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
	localparam logic [1:0] ST_NO_TABLE = 2'd2;

	typedef enum logic [1:0] {
		K_MAP,
		K_UNMAP,
		K_XLATE,
		K_NOP
	} kind_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIR,
		S_CLR,
		S_TBL,
		S_RESP
	} bstate_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  dir_idx;
		logic [IDX_W-1:0]  tix;
		logic [11:0]       offset;
		logic [31:0]       entry;
	} cmd_t;

endpackage

// File: rtl/two_level_page_table_engine.sv
// Top level of the two-level page table engine.
`timescale 1ns / 1ps

// Two-level 10/10/12 page table engine. Each input transaction maps a page,
// unmaps a page or translates an address, and yields exactly one result
// transaction, in order. A front stage registers and classifies the
// transaction and hands it through a two-entry queue to a back stage that
// owns the 1024-entry directory and the table store (128 tables of 1024
// entries) and runs the accesses. After reset the back stage sweeps the
// directory once, one entry a cycle; no transaction is taken until then. In
// the back stage a map into an existing table, an unmap or an unused action
// code runs the directory read and the response state; a translate adds a
// table read (the directory read and the table read depend on each other);
// a map that needs a new table adds a clear state, in which the fresh table
// is cleared one entry per cycle. The result then leaves through an output
// register that can hold it while the next transaction is already at work.
// Tables are handed out in order and never freed; once the pool is spent, a
// map into a region without a table reports status 2 and changes nothing.
module two_level_page_table_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] virt_addr,
	input  logic [31:0] phys_addr,
	input  logic [11:0] page_flags_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] phys_out,
	output logic [1:0]  status,
	output logic [11:0] page_flags_out
);

	logic           busy;
	logic           q_full;
	logic           q_empty;
	logic           push;
	logic           pop;
	tlpt_pkg::cmd_t push_cmd;
	tlpt_pkg::cmd_t pop_cmd;

	// The front stage stalls while the directory is being cleared and
	// whenever the queue cannot take its registered command.
	tlpt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.virt_addr     (virt_addr),
		.phys_addr     (phys_addr),
		.page_flags_in (page_flags_in),
		.busy          (busy),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	tlpt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// The back stage takes one command at a time and retires it into the
	// output register once that register is free.
	tlpt_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_cmd          (pop_cmd),
		.pop            (pop),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.phys_out       (phys_out),
		.status         (status),
		.page_flags_out (page_flags_out)
	);

endmodule

// File: rtl/tlpt_front.sv
// Front stage: accepts transactions and classifies them into queue commands.
`timescale 1ns / 1ps

module tlpt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [31:0]       virt_addr,
	input  logic [31:0]       phys_addr,
	input  logic [11:0]       page_flags_in,
	input  logic              busy,
	input  logic              q_full,
	output logic              push,
	output tlpt_pkg::cmd_t    push_cmd
);

	logic           f_valid_s1;
	tlpt_pkg::cmd_t f_cmd_s1;
	tlpt_pkg::cmd_t cmd_d;
	logic           accept;

	assign in_stall = busy || (f_valid_s1 && q_full);
	assign accept = in_valid && !in_stall;
	assign push = f_valid_s1 && !q_full;
	assign push_cmd = f_cmd_s1;

	always_comb begin
		case (action)
			tlpt_pkg::ACT_MAP: cmd_d.kind = tlpt_pkg::K_MAP;
			tlpt_pkg::ACT_UNMAP: cmd_d.kind = tlpt_pkg::K_UNMAP;
			tlpt_pkg::ACT_XLATE: cmd_d.kind = tlpt_pkg::K_XLATE;
			default: cmd_d.kind = tlpt_pkg::K_NOP;
		endcase
		cmd_d.dir_idx = virt_addr[31:22];
		cmd_d.tix = virt_addr[21:12];
		cmd_d.offset = virt_addr[11:0];
		// The present bit is always set in a stored entry.
		cmd_d.entry = {phys_addr[31:12], page_flags_in[11:1], 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s1 <= 1'b0;
		end else if (accept) begin
			f_valid_s1 <= 1'b1;
		end else if (push) begin
			f_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: rtl/tlpt_queue.sv
// Short command queue between the front and back stages.
`timescale 1ns / 1ps

module tlpt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlpt_pkg::cmd_t    push_cmd,
	output logic              full,
	input  logic              pop,
	output tlpt_pkg::cmd_t    pop_cmd,
	output logic              empty
);

	tlpt_pkg::cmd_t                   slot_q [tlpt_pkg::Q_DEPTH];
	logic [tlpt_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [tlpt_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [tlpt_pkg::Q_CNT_W-1:0]     cnt_q;

	assign full = (cnt_q == tlpt_pkg::Q_CNT_W'(tlpt_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/tlpt_back.sv
// Back stage: directory and table memories, the access sequencer and the result register.
`timescale 1ns / 1ps

module tlpt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  tlpt_pkg::cmd_t    q_cmd,
	output logic              pop,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       phys_out,
	output logic [1:0]        status,
	output logic [11:0]       page_flags_out
);

	logic [tlpt_pkg::DIR_W-1:0] dir_mem [tlpt_pkg::DIR_ENTRIES];
	logic [31:0]                tbl_mem [tlpt_pkg::TSTORE_DEPTH];

	tlpt_pkg::bstate_t            state_q, state_d;
	tlpt_pkg::cmd_t               cmd_q;
	logic [tlpt_pkg::DIR_W-1:0]   dir_rd_q;
	logic [31:0]                  tbl_rd_q;
	logic [tlpt_pkg::IDX_W-1:0]   cnt_q;
	logic [tlpt_pkg::USED_W-1:0]  used_q;
	logic [tlpt_pkg::TBL_W-1:0]   new_tbl_q;
	logic [31:0]                  res_phys_q;
	logic [1:0]                   res_status_q;
	logic [11:0]                  res_flags_q;
	logic                         out_valid_q;
	logic [31:0]                  out_phys_q;
	logic [1:0]                   out_status_q;
	logic [11:0]                  out_flags_q;

	logic                         dir_we, dir_re;
	logic [tlpt_pkg::IDX_W-1:0]   dir_waddr;
	logic [tlpt_pkg::DIR_W-1:0]   dir_wdata;
	logic                         tbl_we, tbl_re;
	logic [tlpt_pkg::TADDR_W-1:0] tbl_waddr;
	logic [31:0]                  tbl_wdata;
	logic                         res_ld, alloc, cnt_inc, out_ld;
	logic [31:0]                  res_phys_d;
	logic [1:0]                   res_status_d;
	logic [11:0]                  res_flags_d;
	logic                         dir_present;
	logic [tlpt_pkg::TBL_W-1:0]   dir_tbl;
	logic [tlpt_pkg::TADDR_W-1:0] slot_addr;
	logic                         cnt_last;

	assign dir_present = dir_rd_q[tlpt_pkg::DIR_W-1];
	assign dir_tbl = dir_rd_q[tlpt_pkg::TBL_W-1:0];
	assign slot_addr = {dir_tbl, cmd_q.tix};
	assign cnt_last = (cnt_q == '1);
	assign busy = (state_q == tlpt_pkg::S_INIT);

	assign out_valid = out_valid_q;
	assign phys_out = out_phys_q;
	assign status = out_status_q;
	assign page_flags_out = out_flags_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlpt_pkg::S_INIT: begin
				if (cnt_last) begin
					state_d = tlpt_pkg::S_IDLE;
				end
			end
			tlpt_pkg::S_IDLE: begin
				if (!q_empty) begin
					state_d = tlpt_pkg::S_DIR;
				end
			end
			tlpt_pkg::S_DIR: begin
				state_d = tlpt_pkg::S_RESP;
				if (cmd_q.kind == tlpt_pkg::K_MAP && !dir_present &&
						used_q != tlpt_pkg::POOL_FULL) begin
					state_d = tlpt_pkg::S_CLR;
				end else if (cmd_q.kind == tlpt_pkg::K_XLATE && dir_present) begin
					state_d = tlpt_pkg::S_TBL;
				end
			end
			tlpt_pkg::S_CLR: begin
				if (cnt_last) begin
					state_d = tlpt_pkg::S_RESP;
				end
			end
			tlpt_pkg::S_TBL: begin
				state_d = tlpt_pkg::S_RESP;
			end
			tlpt_pkg::S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = tlpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tlpt_pkg::S_INIT;
			end
		endcase
	end

	// State outputs: memory controls, result and counter updates.
	always_comb begin
		pop = 1'b0;
		dir_we = 1'b0;
		dir_re = 1'b0;
		dir_waddr = cmd_q.dir_idx;
		dir_wdata = '0;
		tbl_we = 1'b0;
		tbl_re = 1'b0;
		tbl_waddr = slot_addr;
		tbl_wdata = '0;
		res_ld = 1'b0;
		res_phys_d = '0;
		res_status_d = tlpt_pkg::ST_OK;
		res_flags_d = '0;
		alloc = 1'b0;
		cnt_inc = 1'b0;
		out_ld = 1'b0;
		case (state_q)
			tlpt_pkg::S_INIT: begin
				dir_we = 1'b1;
				dir_waddr = cnt_q;
				cnt_inc = 1'b1;
			end
			tlpt_pkg::S_IDLE: begin
				pop = !q_empty;
				dir_re = !q_empty;
			end
			tlpt_pkg::S_DIR: begin
				res_ld = 1'b1;
				case (cmd_q.kind)
					tlpt_pkg::K_MAP: begin
						if (dir_present) begin
							tbl_we = 1'b1;
							tbl_wdata = cmd_q.entry;
						end else if (used_q == tlpt_pkg::POOL_FULL) begin
							res_status_d = tlpt_pkg::ST_NO_TABLE;
						end else begin
							dir_we = 1'b1;
							dir_wdata = {1'b1, used_q[tlpt_pkg::TBL_W-1:0]};
							alloc = 1'b1;
							res_ld = 1'b0;
						end
					end
					tlpt_pkg::K_UNMAP: begin
						tbl_we = dir_present;
					end
					tlpt_pkg::K_XLATE: begin
						if (dir_present) begin
							tbl_re = 1'b1;
							res_ld = 1'b0;
						end else begin
							res_status_d = tlpt_pkg::ST_NOT_MAPPED;
						end
					end
					default: begin
						res_status_d = tlpt_pkg::ST_OK;
					end
				endcase
			end
			tlpt_pkg::S_CLR: begin
				// The new table is cleared, with the mapped entry dropped in on the way.
				tbl_we = 1'b1;
				tbl_waddr = {new_tbl_q, cnt_q};
				tbl_wdata = (cnt_q == cmd_q.tix) ? cmd_q.entry : 32'd0;
				cnt_inc = 1'b1;
				res_ld = cnt_last;
			end
			tlpt_pkg::S_TBL: begin
				res_ld = 1'b1;
				if (tbl_rd_q[0]) begin
					res_phys_d = {tbl_rd_q[31:12], cmd_q.offset};
					res_flags_d = tbl_rd_q[11:0];
				end else begin
					res_status_d = tlpt_pkg::ST_NOT_MAPPED;
				end
			end
			tlpt_pkg::S_RESP: begin
				out_ld = !out_valid_q || !out_stall;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpt_pkg::S_INIT;
			cnt_q <= '0;
			used_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (alloc) begin
				cnt_q <= '0;
				used_q <= used_q + 1'b1;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (alloc) begin
			new_tbl_q <= used_q[tlpt_pkg::TBL_W-1:0];
		end
		if (res_ld) begin
			res_phys_q <= res_phys_d;
			res_status_q <= res_status_d;
			res_flags_q <= res_flags_d;
		end
		if (out_ld) begin
			out_phys_q <= res_phys_q;
			out_status_q <= res_status_q;
			out_flags_q <= res_flags_q;
		end
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[q_cmd.dir_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[slot_addr];
		end
	end

endmodule
